@@ hdl/median_filter_3x3_stream_macros.svh @@
// Assertion macros for the 3x3 median filter stream.
// Used by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef MEDIAN_FILTER_3X3_STREAM_MACROS_SVH
`define MEDIAN_FILTER_3X3_STREAM_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define MFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mfs_pkg.sv @@
// Shared constants, types and compare helpers for the 3x3 median filter stream.
// No dependencies.
`default_nettype none
package mfs_pkg;

    localparam int MFS_MAX_WIDTH    = 4096;
    localparam int MFS_MAX_CHANNELS = 4;
    localparam int MFS_SAMPLE_BITS  = 16;
    localparam int MFS_QDEPTH       = 2;
    localparam int ROW_BITS         = 16;
    localparam int CFG_IDX_BITS     = 2;
    localparam int CFG_DATA_BITS    = 16;
    localparam int NUM_PORT_CH      = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // result kinds of one input pixel, in emission order
    localparam logic [1:0] EM_MID_UP   = 2'd0;  // (x-1, y-1)
    localparam logic [1:0] EM_MID_LAST = 2'd1;  // (x-1, y) in last row
    localparam logic [1:0] EM_END_UP   = 2'd2;  // (W-1, y-1)
    localparam logic [1:0] EM_END_LAST = 2'd3;  // (W-1, y) in last row

    typedef struct packed {
        logic [3:0] mask;   // one bit per result kind
        logic       x_ge1;
        logic       x_ge2;
        logic       y_ge1;
        logic       y_ge2;
    } t_emit_ctl;

    function automatic logic [31:0] min2(input logic [31:0] a, input logic [31:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [31:0] max2(input logic [31:0] a, input logic [31:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [31:0] min3(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [31:0] max3(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [31:0] med3(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage
`default_nettype wire

@@ hdl/median_filter_3x3_stream.sv @@
// 3x3 median filter stream: one pixel accepted per cycle; a result is valid once the
// pixel that completes its window has passed the queue and three median stages.
// Throughput: one result per cycle while i_ready is high; a pixel with several results
// stays at the queue head until its last result issues; intake stalls only once the
// two-entry queue is full. Synchronous active-low reset clears counters, window and
// pipeline; line stores need no clearing, so the block is ready once out of reset.
`default_nettype none
`include "median_filter_3x3_stream_macros.svh"
module median_filter_3x3_stream #(
    parameter int MAX_WIDTH    = mfs_pkg::MFS_MAX_WIDTH,
    parameter int MAX_CHANNELS = mfs_pkg::MFS_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mfs_pkg::MFS_SAMPLE_BITS,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mfs_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mfs_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [SAMPLE_BITS-1:0]               i_sample_c0,
    input  logic [SAMPLE_BITS-1:0]               i_sample_c1,
    input  logic [SAMPLE_BITS-1:0]               i_sample_c2,
    input  logic [SAMPLE_BITS-1:0]               i_sample_c3,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [SAMPLE_BITS-1:0]               o_median_c0,
    output logic [SAMPLE_BITS-1:0]               o_median_c1,
    output logic [SAMPLE_BITS-1:0]               o_median_c2,
    output logic [SAMPLE_BITS-1:0]               o_median_c3,
    output logic [AW-1:0]                        o_out_col,
    output logic [mfs_pkg::ROW_BITS-1:0]         o_out_row,
    output logic                                 o_end_of_image,
    output logic                                 o_last_of_step
);
    import mfs_pkg::*;

    localparam int L  = MAX_CHANNELS;
    localparam int SB = SAMPLE_BITS;
    localparam int DW = 2 * AW + 2 * ROW_BITS + 9 * L * SB;

    logic [12:0]         r_img_w;
    logic [15:0]         r_img_h;
    logic [2:0]          r_ch_cnt;
    logic [AW-1:0]       w_m1;
    logic [ROW_BITS-1:0] h_m1;
    logic [2:0]          nch;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 13'd4096;
            r_img_h  <= 16'd1;
            r_ch_cnt <= 3'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_img_w  <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT:  r_img_h  <= i_cfg_data[15:0];
                CFG_CHANNEL_COUNT: r_ch_cnt <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamp registers to what the hardware supports
    always_comb begin
        if (r_img_w == '0)                   w_m1 = '0;
        else if (32'(r_img_w) > MAX_WIDTH)   w_m1 = AW'(MAX_WIDTH - 1);
        else                                 w_m1 = AW'(r_img_w - 13'd1);
        h_m1 = (r_img_h == '0) ? '0 : r_img_h - 16'd1;
        if (r_ch_cnt == '0)                  nch = 3'd1;
        else if (32'(r_ch_cnt) > MAX_CHANNELS) nch = 3'(MAX_CHANNELS);
        else                                 nch = r_ch_cnt;
    end

    logic [NUM_PORT_CH-1:0][SB-1:0] port_smp, port_med;
    logic [L-1:0][SB-1:0]           lane_smp, lane_med;

    assign port_smp = {i_sample_c3, i_sample_c2, i_sample_c1, i_sample_c0};

    for (genvar g = 0; g < L; g++) begin : g_in
        assign lane_smp[g] = port_smp[g];
    end

    for (genvar g = 0; g < NUM_PORT_CH; g++) begin : g_out
        if (g < L) begin : g_act
            assign port_med[g] = lane_med[g];
        end else begin : g_zero
            assign port_med[g] = '0;
        end
    end

    assign o_median_c0 = port_med[0];
    assign o_median_c1 = port_med[1];
    assign o_median_c2 = port_med[2];
    assign o_median_c3 = port_med[3];

    logic          q_push, q_ready, q_pop, q_valid;
    logic [DW-1:0] q_in_data, q_out_data;
    t_emit_ctl     q_in_ctl, q_out_ctl;

    mfs_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_samples (lane_smp),
        .i_w_m1    (w_m1),
        .i_h_m1    (h_m1),
        .o_push    (q_push),
        .o_data    (q_in_data),
        .o_ctl     (q_in_ctl),
        .i_q_ready (q_ready)
    );

    mfs_queue #(
        .DW    (DW),
        .DEPTH (MFS_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .i_ctl   (q_in_ctl),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out_data),
        .o_ctl   (q_out_ctl)
    );

    mfs_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head_v (q_valid),
        .i_data   (q_out_data),
        .i_ctl    (q_out_ctl),
        .o_pop    (q_pop),
        .i_nch    (nch),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_med    (lane_med),
        .o_col    (o_out_col),
        .o_row    (o_out_row),
        .o_eoi    (o_end_of_image),
        .o_last   (o_last_of_step)
    );

    `MFS_ASSERT_SAME(a_push_has_room, q_push, q_ready, "push into a full queue")
    `MFS_ASSERT_SAME(a_pop_has_head, q_pop, q_valid, "pop from an empty queue")
    `MFS_ASSERT_SAME(a_eoi_is_last, o_valid && o_end_of_image, o_last_of_step,
                     "bottom-right result not marked last")
    `MFS_ASSERT_NEXT(a_empty_pushed_pending, q_push && !q_valid, q_valid,
                     "queue empty after a push")

endmodule
`default_nettype wire

@@ hdl/mfs_queue.sv @@
// Short FIFO between the front and the back of the median filter.
// Depends on mfs_pkg for the control struct.
`default_nettype none
module mfs_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DW-1:0]         i_data,
    input  mfs_pkg::t_emit_ctl    i_ctl,
    output logic                  o_ready,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic [DW-1:0]         o_data,
    output mfs_pkg::t_emit_ctl    o_ctl
);
    import mfs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_data [DEPTH];
    t_emit_ctl     r_ctl  [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt;

    assign o_ready = (r_cnt < CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_data[r_rp];
    assign o_ctl   = r_ctl[r_rp];

    always_comb begin
        n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
            r_ctl[r_wp]  <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= n_wp;
            if (i_pop)  r_rp <= n_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mfs_front.sv @@
// Front of the median filter: counters, line stores, window columns,
// and the list of results each pixel causes. Depends on mfs_pkg.
`default_nettype none
module mfs_front #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int DW = 2 * AW + 2 * mfs_pkg::ROW_BITS + 9 * MAX_CHANNELS * SAMPLE_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0]     i_samples,
    input  logic [AW-1:0]                                i_w_m1,
    input  logic [mfs_pkg::ROW_BITS-1:0]                 i_h_m1,
    output logic                                         o_push,
    output logic [DW-1:0]                                o_data,
    output mfs_pkg::t_emit_ctl                           o_ctl,
    input  logic                                         i_q_ready
);
    import mfs_pkg::*;

    localparam int L  = MAX_CHANNELS;
    localparam int SB = SAMPLE_BITS;

    typedef logic [L-1:0][SB-1:0] t_pix;

    t_pix mem_old [MAX_WIDTH];
    t_pix mem_new [MAX_WIDTH];

    logic [AW-1:0]       r_col, r_x, x;
    logic [ROW_BITS-1:0] r_row, r_y, y;
    logic                r_s1_v, r_byp, r_xlast, r_ylast;
    t_pix                r_smp, r_rd_o, r_rd_n, r_wo, r_wn;
    logic [2:0][L-1:0][SB-1:0] r_win_a, r_win_b, cur;
    logic                acc, s1_go, x_last, y_last;
    t_emit_ctl           ctl;

    always_comb begin
        x      = (r_col < i_w_m1) ? r_col : i_w_m1;
        y      = (r_row < i_h_m1) ? r_row : i_h_m1;
        x_last = (x == i_w_m1);
        y_last = (y == i_h_m1);
    end

    always_comb begin
        ctl.x_ge1 = (r_x != '0);
        ctl.x_ge2 = (r_x > AW'(1));
        ctl.y_ge1 = (r_y != '0);
        ctl.y_ge2 = (r_y > ROW_BITS'(1));
        ctl.mask[EM_MID_UP]   = ctl.x_ge1 && ctl.y_ge1;
        ctl.mask[EM_MID_LAST] = ctl.x_ge1 && r_ylast;
        ctl.mask[EM_END_UP]   = r_xlast && ctl.y_ge1;
        ctl.mask[EM_END_LAST] = r_xlast && r_ylast;
    end

    // a pixel with no results only updates state, it never waits on the queue
    assign s1_go   = r_s1_v && (i_q_ready || (ctl.mask == '0));
    assign o_ready = !r_s1_v || s1_go;
    assign acc     = i_valid && o_ready;
    assign o_push  = s1_go && (ctl.mask != '0);
    assign o_ctl   = ctl;

    always_comb begin
        cur[0] = r_byp ? r_wo : r_rd_o;
        cur[1] = r_byp ? r_wn : r_rd_n;
        cur[2] = r_smp;
    end

    assign o_data = {r_x - 1'b1, r_x, r_y - 1'b1, r_y, cur, r_win_b, r_win_a};

    // line stores: read on accept, written when the pixel leaves the front
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_o <= mem_old[x];
            r_rd_n <= mem_new[x];
        end
        if (s1_go) begin
            mem_old[r_x] <= cur[1];
            mem_new[r_x] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_x     <= x;
            r_y     <= y;
            r_smp   <= i_samples;
            r_xlast <= x_last;
            r_ylast <= y_last;
        end
        if (s1_go) begin
            r_wo <= cur[1];
            r_wn <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_s1_v  <= 1'b0;
            r_byp   <= 1'b0;
            r_win_a <= '0;
            r_win_b <= '0;
        end else begin
            if (acc) begin
                // same column being written this edge: take the write data instead
                r_byp <= s1_go && (r_x == x);
                if (x_last) begin
                    r_col <= '0;
                    r_row <= y_last ? '0 : y + 1'b1;
                end else begin
                    r_col <= x + 1'b1;
                    r_row <= y;
                end
            end
            if (acc)        r_s1_v <= 1'b1;
            else if (s1_go) r_s1_v <= 1'b0;
            if (s1_go) begin
                r_win_a <= r_win_b;
                r_win_b <= cur;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/mfs_back.sv @@
// Back of the median filter: walks the results of each queued pixel and runs
// them through a three-stage median network. Depends on mfs_pkg.
`default_nettype none
module mfs_back #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int DW = 2 * AW + 2 * mfs_pkg::ROW_BITS + 9 * MAX_CHANNELS * SAMPLE_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_head_v,
    input  logic [DW-1:0]                            i_data,
    input  mfs_pkg::t_emit_ctl                       i_ctl,
    output logic                                     o_pop,
    input  logic [2:0]                               i_nch,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] o_med,
    output logic [AW-1:0]                            o_col,
    output logic [mfs_pkg::ROW_BITS-1:0]             o_row,
    output logic                                     o_eoi,
    output logic                                     o_last
);
    import mfs_pkg::*;

    localparam int L  = MAX_CHANNELS;
    localparam int SB = SAMPLE_BITS;

    logic [AW-1:0]       col_a, col_b;
    logic [ROW_BITS-1:0] row_a, row_b;
    logic [2:0][2:0][L-1:0][SB-1:0] win;

    assign {col_a, col_b, row_a, row_b, win} = i_data;

    logic [3:0] r_done, rem, sel;
    logic [1:0] kind, lc, mc, rc, rt, rm, rb;
    logic       last, issue;
    logic       p1_free, p2_free, out_free;

    logic                           r_p1_v, r_p2_v, r_out_v;
    logic [L-1:0][8:0][SB-1:0]      r_p1_val;
    logic [L-1:0][2:0][SB-1:0]      r_p2_lo, r_p2_mid, r_p2_hi;
    logic [AW-1:0]                  r_p1_col, r_p2_col;
    logic [ROW_BITS-1:0]            r_p1_row, r_p2_row;
    logic                           r_p1_eoi, r_p2_eoi, r_p1_last, r_p2_last;

    // pick the earliest pending result of the head pixel
    always_comb begin
        rem = i_ctl.mask & ~r_done;
        if (rem[EM_MID_UP])        kind = EM_MID_UP;
        else if (rem[EM_MID_LAST]) kind = EM_MID_LAST;
        else if (rem[EM_END_UP])   kind = EM_END_UP;
        else                       kind = EM_END_LAST;
        sel  = 4'b0001 << kind;
        last = ((rem & ~sel) == '0);
    end

    always_comb begin
        case (kind)
            EM_MID_UP, EM_MID_LAST: begin
                lc = i_ctl.x_ge2 ? 2'd0 : 2'd1;
                mc = 2'd1;
                rc = 2'd2;
            end
            default: begin
                lc = i_ctl.x_ge1 ? 2'd1 : 2'd2;
                mc = 2'd2;
                rc = 2'd2;
            end
        endcase
        case (kind)
            EM_MID_UP, EM_END_UP: begin
                rt = i_ctl.y_ge2 ? 2'd0 : 2'd1;
                rm = 2'd1;
                rb = 2'd2;
            end
            default: begin
                rt = i_ctl.y_ge1 ? 2'd1 : 2'd2;
                rm = 2'd2;
                rb = 2'd2;
            end
        endcase
    end

    assign out_free = !r_out_v || i_ready;
    assign p2_free  = !r_p2_v || out_free;
    assign p1_free  = !r_p1_v || p2_free;
    assign issue    = i_head_v && p1_free;
    assign o_pop    = issue && last;

    always_ff @(posedge i_clk) begin
        if (issue) begin
            for (int i = 0; i < L; i++) begin
                r_p1_val[i][0] <= win[lc][rt][i];
                r_p1_val[i][1] <= win[mc][rt][i];
                r_p1_val[i][2] <= win[rc][rt][i];
                r_p1_val[i][3] <= win[lc][rm][i];
                r_p1_val[i][4] <= win[mc][rm][i];
                r_p1_val[i][5] <= win[rc][rm][i];
                r_p1_val[i][6] <= win[lc][rb][i];
                r_p1_val[i][7] <= win[mc][rb][i];
                r_p1_val[i][8] <= win[rc][rb][i];
            end
            r_p1_col  <= kind[1] ? col_b : col_a;
            r_p1_row  <= kind[0] ? row_b : row_a;
            r_p1_eoi  <= (kind == EM_END_LAST);
            r_p1_last <= last;
        end
        // sort each row of three
        if (r_p1_v && p2_free) begin
            for (int i = 0; i < L; i++) begin
                for (int r = 0; r < 3; r++) begin
                    r_p2_lo[i][r]  <= SB'(min3(32'(r_p1_val[i][3*r]), 32'(r_p1_val[i][3*r+1]),
                                               32'(r_p1_val[i][3*r+2])));
                    r_p2_mid[i][r] <= SB'(med3(32'(r_p1_val[i][3*r]), 32'(r_p1_val[i][3*r+1]),
                                               32'(r_p1_val[i][3*r+2])));
                    r_p2_hi[i][r]  <= SB'(max3(32'(r_p1_val[i][3*r]), 32'(r_p1_val[i][3*r+1]),
                                               32'(r_p1_val[i][3*r+2])));
                end
            end
            r_p2_col  <= r_p1_col;
            r_p2_row  <= r_p1_row;
            r_p2_eoi  <= r_p1_eoi;
            r_p2_last <= r_p1_last;
        end
        // median of nine from the sorted rows; inactive channels read zero
        if (r_p2_v && out_free) begin
            for (int i = 0; i < L; i++) begin
                if (3'(i) < i_nch) begin
                    o_med[i] <= SB'(med3(
                        max3(32'(r_p2_lo[i][0]), 32'(r_p2_lo[i][1]), 32'(r_p2_lo[i][2])),
                        med3(32'(r_p2_mid[i][0]), 32'(r_p2_mid[i][1]), 32'(r_p2_mid[i][2])),
                        min3(32'(r_p2_hi[i][0]), 32'(r_p2_hi[i][1]), 32'(r_p2_hi[i][2]))));
                end else begin
                    o_med[i] <= '0;
                end
            end
            o_col  <= r_p2_col;
            o_row  <= r_p2_row;
            o_eoi  <= r_p2_eoi;
            o_last <= r_p2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (issue) r_done <= last ? '0 : (r_done | sel);
            if (p1_free)  r_p1_v  <= issue;
            if (p2_free)  r_p2_v  <= r_p1_v;
            if (out_free) r_out_v <= r_p2_v;
        end
    end

    assign o_valid = r_out_v;

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for median_filter_3x3_stream: streams whole images and checks every
// result against an in-bench prediction of the 3x3 median with replicated borders.
// Depends on mfs_pkg and the median_filter_3x3_stream RTL.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mfs_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  MAXW        = 4096;

    typedef struct {
        logic [15:0] med [4];
        logic [11:0] col;
        logic [15:0] row;
        logic        eoi;
        logic        last;
    } median_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_sample_c0, i_sample_c1, i_sample_c2, i_sample_c3;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_median_c0, o_median_c1, o_median_c2, o_median_c3;
    logic [11:0] o_out_col;
    logic [15:0] o_out_row;
    logic        o_end_of_image;
    logic        o_last_of_step;

    median_filter_3x3_stream i_dut (.*);

    // predictor state
    logic [15:0] line_old [MAXW][4];
    logic [15:0] line_new [MAXW][4];
    logic [15:0] win_cols [2][3][4];
    logic [15:0] col_l [3][4], col_m [3][4], col_r [3][4];
    int          col_ctr, row_ctr;
    logic [12:0] reg_width;
    logic [15:0] reg_height;
    logic [2:0]  reg_channels;
    median_t     expected_q [$];

    int  errors;
    int  cycles;
    bit  tx_idle, rx_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("median_filter_3x3_stream regression: fail");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] median9(input logic [15:0] v [9]);
        logic [15:0] t;
        for (int i = 0; i < 9; i++)
            for (int j = 0; j < 8 - i; j++)
                if (v[j] > v[j+1]) begin
                    t = v[j]; v[j] = v[j+1]; v[j+1] = t;
                end
        return v[4];
    endfunction

    // window rows: 0 top, 1 middle, 2 bottom picked from col_l/col_m/col_r
    task automatic push_median(input int rt, input int rm, input int rb, input int nch,
                               input int col, input int row, input logic eoi);
        median_t     r;
        logic [15:0] v [9];
        for (int ch = 0; ch < 4; ch++) begin
            v = '{col_l[rt][ch], col_m[rt][ch], col_r[rt][ch],
                  col_l[rm][ch], col_m[rm][ch], col_r[rm][ch],
                  col_l[rb][ch], col_m[rb][ch], col_r[rb][ch]};
            r.med[ch] = (ch < nch) ? median9(v) : 16'd0;
        end
        r.col  = col[11:0];
        r.row  = row[15:0];
        r.eoi  = eoi;
        r.last = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic predict_pixel(input logic [15:0] s0, s1, s2, s3);
        int          w, h, nch, x, y, n0;
        logic [15:0] cur [3][4];
        logic [15:0] smp [4];
        smp = '{s0, s1, s2, s3};
        w   = (reg_width < 1) ? 1 : (reg_width > MAXW ? MAXW : reg_width);
        h   = (reg_height < 1) ? 1 : reg_height;
        nch = (reg_channels < 1) ? 1 : (reg_channels > 4 ? 4 : reg_channels);
        x   = (col_ctr < w - 1) ? col_ctr : w - 1;
        y   = (row_ctr < h - 1) ? row_ctr : h - 1;
        n0  = expected_q.size();
        for (int ch = 0; ch < 4; ch++) begin
            cur[0][ch] = line_old[x][ch];
            cur[1][ch] = line_new[x][ch];
            cur[2][ch] = smp[ch];
            line_old[x][ch] = cur[1][ch];
            line_new[x][ch] = cur[2][ch];
        end
        if (x >= 1) begin
            col_l = (x >= 2) ? win_cols[0] : win_cols[1];
            col_m = win_cols[1];
            col_r = cur;
            if (y >= 1) push_median((y >= 2) ? 0 : 1, 1, 2, nch, x - 1, y - 1, 1'b0);
            if (y == h - 1) push_median((y >= 1) ? 1 : 2, 2, 2, nch, x - 1, y, 1'b0);
        end
        if (x == w - 1) begin
            col_l = (x >= 1) ? win_cols[1] : cur;
            col_m = cur;
            col_r = cur;
            if (y >= 1) push_median((y >= 2) ? 0 : 1, 1, 2, nch, w - 1, y - 1, 1'b0);
            if (y == h - 1) push_median((y >= 1) ? 1 : 2, 2, 2, nch, w - 1, y, 1'b1);
        end
        if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
        win_cols[0] = win_cols[1];
        win_cols[1] = cur;
        if (x == w - 1) begin
            col_ctr = 0;
            row_ctr = (y == h - 1) ? 0 : y + 1;
        end else begin
            col_ctr = x + 1;
            row_ctr = y;
        end
    endtask

    task automatic send_pixel(input logic [15:0] s0, s1, s2, s3);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_sample_c0 <= s0;
        i_sample_c1 <= s1;
        i_sample_c2 <= s2;
        i_sample_c3 <= s3;
        do @(posedge i_clk); while (!o_ready);
        predict_pixel(s0, s1, s2, s3);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // wait out the pipeline so the block is idle before a register write
    task automatic drain();
        drop_valid();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:   reg_width    = data[12:0];
            CFG_IMAGE_HEIGHT:  reg_height   = data;
            CFG_CHANNEL_COUNT: reg_channels = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic [15:0] c);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, c);
    endtask

    function automatic int pixels_per_image();
        int w, h;
        w = (reg_width < 1) ? 1 : (reg_width > MAXW ? MAXW : reg_width);
        h = (reg_height < 1) ? 1 : reg_height;
        return w * h;
    endfunction

    // mode 0: full random, 1: narrow range for ties, 2: only extremes
    function automatic logic [15:0] rand_sample(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(100, 103));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic send_random_pixels(input int mode, input int n);
        for (int i = 0; i < n; i++)
            send_pixel(rand_sample(mode), rand_sample(mode), rand_sample(mode),
                       rand_sample(mode));
        drain();
    endtask

    task automatic send_random_image(input int mode);
        send_random_pixels(mode, pixels_per_image());
    endtask

    // result checker
    always @(posedge i_clk) begin
        median_t e;
        logic [15:0] got [4];
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result at row", o_out_row, -1);
            end else begin
                e   = expected_q.pop_front();
                got = '{o_median_c0, o_median_c1, o_median_c2, o_median_c3};
                for (int ch = 0; ch < 4; ch++)
                    if (got[ch] !== e.med[ch])
                        report($sformatf("median_c%0d at (%0d,%0d)", ch, e.col, e.row),
                               got[ch], e.med[ch]);
                if (o_out_col !== e.col) report("out_col", o_out_col, e.col);
                if (o_out_row !== e.row) report("out_row", o_out_row, e.row);
                if (o_end_of_image !== e.eoi) report("end_of_image", o_end_of_image, e.eoi);
                if (o_last_of_step !== e.last) report("last_of_step", o_last_of_step, e.last);
            end
        end
    end

    // result side stalls
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = rx_idle ? $urandom_range(0, 19) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic test_reset_values();
        tx_idle = 1; rx_idle = 1;
        // part of a row at the reset width, then narrow it: the counter past the edge
        // is taken as the last column and ends the row
        send_random_pixels(0, 16);
        configure(16'd4, 16'd1, 16'd4);
        send_random_pixels(0, 1);
    endtask

    task automatic test_directed();
        tx_idle = 1; rx_idle = 1;
        configure(16'd3, 16'd3, 16'd4);
        send_pixel(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA);
        send_pixel(16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555);
        send_pixel(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE);
        send_pixel(16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h1234, 16'h1234, 16'h1234, 16'h1234);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0);
        drain();
        // zero registers clamp to one pixel, one row, one channel
        configure(16'd0, 16'd0, 16'd0);
        send_pixel(16'hBEEF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
        // channel count above four clamps to four; width bits above 12 drop
        configure(16'hE002, 16'd2, 16'd7);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        drain();
    endtask

    task automatic test_widest_row();
        tx_idle = 0; rx_idle = 0;
        configure(16'hFFFF, 16'd1, 16'd3);     // width clamps to 4096
        send_random_pixels(0, 12);
        // close the row at the current column
        configure(16'd13, 16'd1, 16'd3);
        send_random_pixels(0, 1);
    endtask

    task automatic test_tallest_column();
        tx_idle = 0; rx_idle = 0;
        configure(16'd1, 16'd8, 16'd1);
        send_random_image(0);
    endtask

    task automatic test_random_images();
        int sent;
        sent = 0;
        while (sent < 70) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                      16'($urandom_range(0, 7)));
            sent += pixels_per_image();
            send_random_image($urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 2));
        end
    endtask

    initial begin
        errors       = 0;
        cycles       = 0;
        tx_idle      = 0;
        rx_idle      = 0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_sample_c0  = '0;
        i_sample_c1  = '0;
        i_sample_c2  = '0;
        i_sample_c3  = '0;
        col_ctr      = 0;
        row_ctr      = 0;
        reg_width    = 13'd4096;
        reg_height   = 16'd1;
        reg_channels = 3'd4;
        for (int i = 0; i < MAXW; i++)
            for (int ch = 0; ch < 4; ch++) begin
                line_old[i][ch] = '0;
                line_new[i][ch] = '0;
            end
        win_cols = '{default: '{default: '{default: 16'd0}}};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed();
        test_widest_row();
        test_tallest_column();
        test_random_images();

        drop_valid();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("median_filter_3x3_stream regression: pass");
        end else begin
            $display("median_filter_3x3_stream regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/mfs_pkg.sv
hdl/mfs_queue.sv
hdl/mfs_front.sv
hdl/mfs_back.sv
hdl/median_filter_3x3_stream.sv
bench/testbench.sv
